[rtl/klock_pkg.sv]
// ----------------------------------------------------------------------------
// klock_pkg
// Shared types and constants of the keypad code lock.
// ----------------------------------------------------------------------------
package klock_pkg;

  localparam int          CODE_DIGITS_DEF   = 4;
  localparam logic [7:0]  KEY_NONE          = 8'hFF;
  localparam logic [7:0]  KEY_ZERO          = 8'h30;
  localparam logic [3:0]  TRY_LIMIT_RST     = 4'd3;
  localparam logic [7:0]  LOCKOUT_TICKS_RST = 8'd9;

  localparam int          CFG_IDX_W         = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS = 1'b1;

  localparam logic        FUNC_KEY          = 1'b0;
  localparam logic        FUNC_TICK         = 1'b1;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_CONFIRM,
    PH_USE,
    PH_LOCKOUT,
    PH_OPEN
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_DIGIT,
    EV_MISMATCH,
    EV_STORED,
    EV_WRONG,
    EV_OPENED,
    EV_LOCK,
    EV_RELEASE
  } event_t;

  typedef struct packed {
    event_t      ev;
    logic [3:0]  tries;
    logic [2:0]  digits;
    logic        unlocked;
    logic [7:0]  lockout;
  } res_t;

endpackage

[rtl/keypad_code_lock_unit.sv]
// ----------------------------------------------------------------------------
// keypad_code_lock_unit
// Keypad combination lock with set-up, confirm, tries and timed lockout.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while the output buffer is not full,
// and its result is ready in that buffer on the next cycle. Phase and
// counters update in the cycle of the transfer; the entered and the stored
// code digits live in two small RAMs that are always read ahead at the next
// digit position, so each key is compared against data already registered.
// The buffer holds two results, so input keeps flowing while the output
// stalls until it is full. The digit stores need no clearing pass after reset.
module keypad_code_lock_unit
  import klock_pkg::*;
#(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic [7:0]           key_code,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           event_res,
  output logic [3:0]           tries_left,
  output logic [2:0]           digits_entered,
  output logic                 unlocked,
  output logic [7:0]           lockout_left,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int AW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  logic [3:0]    try_limit;
  logic [7:0]    lockout_ticks;
  logic          acc;
  logic          full;
  logic          first_we;
  logic          code_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    first_q;
  logic [7:0]    code_q;
  res_t          res;
  res_t          dout;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && !full;
  assign acc       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      try_limit     <= TRY_LIMIT_RST;
      lockout_ticks <= LOCKOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRY_LIMIT:     try_limit     <= cfg_data[3:0];
        CFG_LOCKOUT_TICKS: lockout_ticks <= cfg_data;
        default:           try_limit     <= try_limit;
      endcase
    end
  end

  klock_ctrl #(
    .CODE_DIGITS (CODE_DIGITS),
    .AW          (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .acc           (acc),
    .func          (func),
    .key_code      (key_code),
    .try_limit     (try_limit),
    .lockout_ticks (lockout_ticks),
    .first_q       (first_q),
    .code_q        (code_q),
    .first_we      (first_we),
    .code_we       (code_we),
    .waddr         (waddr),
    .raddr         (raddr),
    .res           (res)
  );

  // first entry of set-up
  klock_mem #(
    .DEPTH (CODE_DIGITS),
    .WIDTH (8),
    .AW    (AW)
  ) u_first_mem (
    .clk   (clk),
    .we    (first_we),
    .waddr (waddr),
    .wdata (key_code),
    .raddr (raddr),
    .rdata (first_q)
  );

  // confirm digits, the stored code once confirm passes
  klock_mem #(
    .DEPTH (CODE_DIGITS),
    .WIDTH (8),
    .AW    (AW)
  ) u_code_mem (
    .clk   (clk),
    .we    (code_we),
    .waddr (waddr),
    .wdata (key_code),
    .raddr (raddr),
    .rdata (code_q)
  );

  klock_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .din       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign event_res      = dout.ev;
  assign tries_left     = dout.tries;
  assign digits_entered = dout.digits;
  assign unlocked       = dout.unlocked;
  assign lockout_left   = dout.lockout;

endmodule

[rtl/klock_mem.sv]
// ----------------------------------------------------------------------------
// klock_mem
// Digit store: one write port, one registered read port, new data on a
// read of the entry being written.
// ----------------------------------------------------------------------------
module klock_mem #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/klock_ctrl.sv]
// ----------------------------------------------------------------------------
// klock_ctrl
// Lock sequencer: phase, digit position, tries and lockout counters. Digit
// compares use store data prefetched at the current position.
// ----------------------------------------------------------------------------
module klock_ctrl
  import klock_pkg::*;
#(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF,
  parameter int AW          = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          acc,
  input  logic          func,
  input  logic [7:0]    key_code,
  input  logic [3:0]    try_limit,
  input  logic [7:0]    lockout_ticks,
  input  logic [7:0]    first_q,
  input  logic [7:0]    code_q,
  output logic          first_we,
  output logic          code_we,
  output logic [AW-1:0] waddr,
  output logic [AW-1:0] raddr,
  output res_t          res
);

  localparam logic [AW-1:0] POS_LAST = AW'(CODE_DIGITS - 1);

  phase_t      phase, phase_next;
  logic [AW-1:0] position, position_next;
  logic [3:0]  tries, tries_next;
  logic [7:0]  lockout, lockout_next;
  logic        mismatch, mismatch_next;
  logic        all_zero, all_zero_next;
  event_t      ev;
  logic        last;
  logic        key_ok;
  logic        mm;
  logic        az;
  logic [AW+2:0] pos_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      position <= '0;
      tries    <= TRY_LIMIT_RST;
      lockout  <= '0;
      mismatch <= 1'b0;
      all_zero <= 1'b1;
    end else begin
      phase    <= phase_next;
      position <= position_next;
      tries    <= tries_next;
      lockout  <= lockout_next;
      mismatch <= mismatch_next;
      all_zero <= all_zero_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    position_next = position;
    tries_next    = tries;
    lockout_next  = lockout;
    mismatch_next = mismatch;
    all_zero_next = all_zero;
    ev            = EV_NONE;
    first_we      = 1'b0;
    code_we       = 1'b0;
    last          = (position == POS_LAST);
    key_ok        = acc && (func == FUNC_KEY) && (key_code != KEY_NONE);
    mm            = 1'b0;
    az            = 1'b0;

    if (acc && (func == FUNC_TICK)) begin
      if (phase == PH_LOCKOUT) begin
        if (lockout <= 8'd1) begin
          lockout_next  = '0;
          tries_next    = try_limit;
          phase_next    = PH_USE;
          position_next = '0;
          mismatch_next = 1'b0;
          all_zero_next = 1'b1;
          ev            = EV_RELEASE;
        end else begin
          lockout_next = lockout - 8'd1;
        end
      end
    end else if (key_ok) begin
      case (phase)
        PH_FIRST: begin
          first_we = 1'b1;
          ev       = EV_DIGIT;
          if (!last) begin
            position_next = position + AW'(1);
          end else begin
            phase_next    = PH_CONFIRM;
            position_next = '0;
            mismatch_next = 1'b0;
            all_zero_next = 1'b1;
          end
        end
        PH_CONFIRM: begin
          code_we = 1'b1;
          mm      = mismatch || (key_code != first_q);
          if (!last) begin
            position_next = position + AW'(1);
            mismatch_next = mm;
            ev            = EV_DIGIT;
          end else begin
            position_next = '0;
            mismatch_next = 1'b0;
            all_zero_next = 1'b1;
            if (mm) begin
              phase_next = PH_FIRST;
              ev         = EV_MISMATCH;
            end else begin
              phase_next = PH_USE;
              ev         = EV_STORED;
            end
          end
        end
        PH_USE: begin
          mm = mismatch || (key_code != code_q);
          az = all_zero && (key_code == KEY_ZERO);
          if (!last) begin
            position_next = position + AW'(1);
            mismatch_next = mm;
            all_zero_next = az;
            ev            = EV_DIGIT;
          end else begin
            position_next = '0;
            mismatch_next = 1'b0;
            all_zero_next = 1'b1;
            if (az) begin
              phase_next = PH_FIRST;
              ev         = EV_RELEASE;
            end else if (mm) begin
              if (tries <= 4'd1) begin
                tries_next   = '0;
                lockout_next = lockout_ticks;
                phase_next   = PH_LOCKOUT;
                ev           = EV_LOCK;
              end else begin
                tries_next = tries - 4'd1;
                ev         = EV_WRONG;
              end
            end else begin
              phase_next = PH_OPEN;
              ev         = EV_OPENED;
            end
          end
        end
        default: begin
          ev = EV_NONE;
        end
      endcase
    end
  end

  // prefetch the entry of the next digit position
  assign waddr    = position;
  assign raddr    = position_next;
  assign pos_wide = {3'b000, position_next};

  assign res.ev       = ev;
  assign res.tries    = tries_next;
  assign res.digits   = pos_wide[2:0];
  assign res.unlocked = (phase_next == PH_OPEN);
  assign res.lockout  = lockout_next;

endmodule

[rtl/klock_obuf.sv]
// ----------------------------------------------------------------------------
// klock_obuf
// Two-entry result buffer between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module klock_obuf
  import klock_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output res_t dout
);

  logic [1:0] cnt;
  res_t       slot0;
  res_t       slot1;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign full      = (cnt == 2'd2);
  assign dout      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        slot0 <= slot1;
      end else if (push) begin
        slot0 <= din;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end
  end

endmodule
